FILE: hdl/crs_pkg.sv
package crs_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;

    localparam int COORD_W  = 16;
    localparam int SIZE_W   = 15;
    localparam int LEVEL_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] SIZE_MAX         = '1;
    localparam logic [SIZE_W-1:0] RST_BUFFER_WIDTH  = 15'd80;
    localparam logic [SIZE_W-1:0] RST_BUFFER_HEIGHT = 15'd24;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_WIDTH  = 1'b0,
        CFG_BUFFER_HEIGHT = 1'b1
    } t_cfg_idx;

    // active clip: signed corner, saturated unsigned size
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [SIZE_W-1:0]  w;
        logic        [SIZE_W-1:0]  h;
    } t_rect;

    // pushed rectangle, size may be negative
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] h;
    } t_req;

    typedef struct packed {
        logic  en;
        t_rect rect;
    } t_entry;

endpackage

FILE: hdl/clip_rectangle_stack.sv
// channel   direction  handshake                   payload
// cmd in    input      i_in_valid / o_in_ready     i_cmd, i_rect_x/y/width/height
// result    output     o_out_valid / i_out_ready   o_clip_*, o_stack_level, o_push_dropped
// config    input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One command per cycle while o_in_ready is high; its result is registered (output or skid).
// The stack top lives in a register refilled by a registered RAM read each cycle,
// so back-to-back pops and pushes run without bubbles.
// A skid register holds one extra result; o_in_ready drops only when it is full.
// Synchronous active-low reset; empty stack, no clip, buffer 80 x 24. No clearing pass.
module clip_rectangle_stack
    import crs_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [SIZE_W-1:0]         i_cfg_data,

    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cmd,
    input  logic signed [COORD_W-1:0] i_rect_x,
    input  logic signed [COORD_W-1:0] i_rect_y,
    input  logic signed [COORD_W-1:0] i_rect_width,
    input  logic signed [COORD_W-1:0] i_rect_height,

    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COORD_W-1:0] o_clip_x,
    output logic signed [COORD_W-1:0] o_clip_y,
    output logic [SIZE_W-1:0]         o_clip_width,
    output logic [SIZE_W-1:0]         o_clip_height,
    output logic                      o_clip_enabled,
    output logic [LEVEL_W-1:0]        o_stack_level,
    output logic                      o_push_dropped
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);

    typedef struct packed {
        t_rect            rect;
        logic             en;
        logic [LEVEL_W-1:0] level;
        logic             dropped;
    } t_result;

    logic [SIZE_W-1:0] r_bw, r_bh;
    logic [CW-1:0]     r_count, n_count;
    t_rect             r_active, n_active;
    logic              r_en, n_en;
    t_entry            r_top;
    t_entry            mem [STACK_DEPTH];

    logic              in_fire, out_fire, is_push, full, empty;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, rd_addr;
    logic [CW-1:0]     rd_count;
    t_entry            mem_wdata;
    t_rect             base, isect;
    t_req              req;
    logic              dropped;
    t_result           res, r_out, r_skid;
    logic              r_out_valid, r_skid_valid;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw <= RST_BUFFER_WIDTH;
            r_bh <= RST_BUFFER_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BUFFER_WIDTH:  r_bw <= i_cfg_data;
                CFG_BUFFER_HEIGHT: r_bh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign is_push  = (t_cmd'(i_cmd) == CMD_PUSH);
    assign full     = (r_count == COUNT_FULL);
    assign empty    = (r_count == '0);

    assign req  = '{x: i_rect_x, y: i_rect_y, w: i_rect_width, h: i_rect_height};
    assign base = r_en ? r_active : t_rect'{x: '0, y: '0, w: r_bw, h: r_bh};

    crs_isect u_isect (
        .i_base (base),
        .i_req  (req),
        .o_rect (isect)
    );

    always_comb begin
        n_count  = r_count;
        n_active = r_active;
        n_en     = r_en;
        mem_we   = 1'b0;
        dropped  = 1'b0;
        if (in_fire) begin
            if (is_push) begin
                if (full) begin
                    dropped = 1'b1;
                end else begin
                    mem_we   = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_active = isect;
                    n_en     = 1'b1;
                end
            end else if (!empty) begin
                n_count  = r_count - 1'b1;
                n_active = r_top.rect;
                n_en     = r_top.en;
            end
        end
    end

    assign mem_waddr = r_count[AW-1:0];
    assign mem_wdata = '{en: r_en, rect: r_active};
    assign rd_count  = n_count - 1'b1;
    assign rd_addr   = rd_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // r_top always tracks the entry below the next count; forward a same-cycle write
    always_ff @(posedge i_clk) begin
        if (mem_we && (mem_waddr == rd_addr)) begin
            r_top <= mem_wdata;
        end else begin
            r_top <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_active <= '0;
            r_en     <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_active <= n_active;
            r_en     <= n_en;
        end
    end

    assign res = '{rect: n_active, en: n_en, level: LEVEL_W'(n_count), dropped: dropped};

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_in_ready     = !r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_clip_x       = r_out.rect.x;
    assign o_clip_y       = r_out.rect.y;
    assign o_clip_width   = r_out.rect.w;
    assign o_clip_height  = r_out.rect.h;
    assign o_clip_enabled = r_out.en;
    assign o_stack_level  = r_out.level;
    assign o_push_dropped = r_out.dropped;

endmodule

FILE: hdl/crs_isect.sv
module crs_isect
    import crs_pkg::*;
(
    input  t_rect i_base,
    input  t_req  i_req,
    output t_rect o_rect
);

    localparam int EDGE_W = COORD_W + 2;
    localparam int DIFF_W = EDGE_W + 1;

    logic signed [EDGE_W-1:0] ax_l, ax_r, ay_t, ay_b;
    logic signed [EDGE_W-1:0] bx_l, bx_r, by_t, by_b;
    logic signed [EDGE_W-1:0] x1, x2, y1, y2;
    logic signed [DIFF_W-1:0] dx, dy;

    assign ax_l = EDGE_W'(i_base.x);
    assign ay_t = EDGE_W'(i_base.y);
    assign ax_r = ax_l + signed'(EDGE_W'(i_base.w));
    assign ay_b = ay_t + signed'(EDGE_W'(i_base.h));

    assign bx_l = EDGE_W'(i_req.x);
    assign by_t = EDGE_W'(i_req.y);
    assign bx_r = bx_l + EDGE_W'(i_req.w);
    assign by_b = by_t + EDGE_W'(i_req.h);

    assign x1 = (ax_l > bx_l) ? ax_l : bx_l;
    assign y1 = (ay_t > by_t) ? ay_t : by_t;
    assign x2 = (ax_r < bx_r) ? ax_r : bx_r;
    assign y2 = (ay_b < by_b) ? ay_b : by_b;

    assign dx = DIFF_W'(x2) - DIFF_W'(x1);
    assign dy = DIFF_W'(y2) - DIFF_W'(y1);

    always_comb begin
        o_rect.x = x1[COORD_W-1:0];
        o_rect.y = y1[COORD_W-1:0];
        if (dx <= 0) begin
            o_rect.w = '0;
        end else if (dx > signed'(DIFF_W'(SIZE_MAX))) begin
            o_rect.w = SIZE_MAX;
        end else begin
            o_rect.w = dx[SIZE_W-1:0];
        end
        if (dy <= 0) begin
            o_rect.h = '0;
        end else if (dy > signed'(DIFF_W'(SIZE_MAX))) begin
            o_rect.h = SIZE_MAX;
        end else begin
            o_rect.h = dy[SIZE_W-1:0];
        end
    end

endmodule

FILE: hdl/crs_checks.sv
module crs_checks
    import crs_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [COORD_W-1:0] o_clip_x,
    input logic signed [COORD_W-1:0] o_clip_y,
    input logic [SIZE_W-1:0]         o_clip_width,
    input logic [SIZE_W-1:0]         o_clip_height,
    input logic                      o_clip_enabled,
    input logic [LEVEL_W-1:0]        o_stack_level,
    input logic                      o_push_dropped
);

    localparam bit LEVEL_EXACT = (STACK_DEPTH < (1 << LEVEL_W));
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(STACK_DEPTH);

    // result register empties on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_clip_x)
            && $stable(o_clip_y) && $stable(o_clip_width) && $stable(o_clip_height)
            && $stable(o_clip_enabled) && $stable(o_stack_level)
            && $stable(o_push_dropped))
        else $error("stalled result changed");

    // a dropped push only happens on a full stack
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_push_dropped |-> o_stack_level == LEVEL_FULL)
        else $error("push dropped below full");

    // the bottom of the stack always holds the no-clip state
    a_empty_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEVEL_EXACT && o_out_valid && o_stack_level == '0 |-> !o_clip_enabled)
        else $error("clip enabled with empty stack");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEVEL_EXACT && o_out_valid |-> o_stack_level <= LEVEL_FULL)
        else $error("stack level beyond depth");

endmodule

bind clip_rectangle_stack crs_checks #(.STACK_DEPTH(STACK_DEPTH)) u_crs_checks (.*);
